// File: src/bqd_pkg.sv
// Shared types, constants and the sequencer microcode ROM for the biquad section.
`default_nettype none
package bqd_pkg;

    localparam int COEF_WIDTH    = 20;
    localparam int NUM_COEFS     = 5;
    localparam int CFG_INDEX_W   = 3;
    localparam int STEP_W        = 3;
    localparam int COEF_B0_RESET = 65536;

    typedef logic signed [COEF_WIDTH-1:0] coef_t;

    // Coefficient register indexes, also the multiplier coefficient select.
    typedef enum logic [CFG_INDEX_W-1:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } coef_sel_t;

    typedef enum logic {
        MUL_X = 1'b0,
        MUL_Y = 1'b1
    } mul_src_t;

    // Left operand of the adder; the product register is always the right one.
    typedef enum logic [1:0] {
        BASE_ACC  = 2'd0,
        BASE_D1   = 2'd1,
        BASE_D2   = 2'd2,
        BASE_ZERO = 2'd3
    } base_sel_t;

    typedef struct packed {
        logic      mul_en;
        coef_sel_t coef_sel;
        mul_src_t  mul_src;
        base_sel_t base_sel;
        logic      sub;
        logic      acc_en;
        logic      y_en;
        logic      d1_en;
        logic      d2_en;
        logic      last;
    } ucode_t;

    localparam ucode_t UCODE_NOP = '{
        mul_en: 1'b0, coef_sel: COEF_B0, mul_src: MUL_X, base_sel: BASE_ACC,
        sub: 1'b0, acc_en: 1'b0, y_en: 1'b0, d1_en: 1'b0, d2_en: 1'b0, last: 1'b0
    };

    // Program: y = b0*x + d1; d1 = d2 + b1*x - a1*y; d2 = b2*x - a2*y.
    // A product issued at one step is added at the next.
    function automatic ucode_t ucode_word(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = UCODE_NOP;
        unique case (step)
            3'd0: begin
                w.mul_en = 1'b1; w.coef_sel = COEF_B0; w.mul_src = MUL_X;
            end
            3'd1: begin
                w.mul_en = 1'b1; w.coef_sel = COEF_B1; w.mul_src = MUL_X;
                w.base_sel = BASE_D1; w.acc_en = 1'b1;
            end
            3'd2: begin
                // acc holds b0*x + d1 here: round it into y
                w.y_en = 1'b1;
                w.base_sel = BASE_D2; w.acc_en = 1'b1;
            end
            3'd3: begin
                w.mul_en = 1'b1; w.coef_sel = COEF_A1; w.mul_src = MUL_Y;
            end
            3'd4: begin
                w.mul_en = 1'b1; w.coef_sel = COEF_A2; w.mul_src = MUL_Y;
                w.base_sel = BASE_ACC; w.sub = 1'b1; w.d1_en = 1'b1;
            end
            3'd5: begin
                w.mul_en = 1'b1; w.coef_sel = COEF_B2; w.mul_src = MUL_X;
                w.base_sel = BASE_ZERO; w.sub = 1'b1; w.acc_en = 1'b1;
            end
            3'd6: begin
                w.base_sel = BASE_ACC; w.d2_en = 1'b1; w.last = 1'b1;
            end
            default: begin
                w = UCODE_NOP;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: src/biquad_iir_filter.sv
// Biquad IIR section, transposed direct form II, run by a microcoded sequencer.
// From input word to output register the program runs 7 ROM steps on one multiplier.
// The input stays closed while a word is in work; it is ready again as soon as the
// result lands in the output register, which then waits for the sink on its own.
// The last step holds while an earlier result still sits unread in the output register.
// Reset (aresetn low, synchronous) clears the state words, sets b0 = 1.0 and others 0.
`default_nettype none
module biquad_iir_filter #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 16,
    parameter int STATE_WIDTH    = 40
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [bqd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [bqd_pkg::COEF_WIDTH-1:0]       cfg_data,
    // input samples
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,  // [SAMPLE_WIDTH-1:0] sample_in
    // output samples
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]         m_tdata,  // [SAMPLE_WIDTH-1:0] sample_out
    output logic                                      m_tuser   // [0] clipped
);
    import bqd_pkg::*;

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int PROD_W  = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int ACC_A   = ((PROD_W > STATE_WIDTH) ? PROD_W : STATE_WIDTH) + 2;
    localparam int ACC_B   = SAMPLE_WIDTH + COEF_FRAC_BITS + 2;
    localparam int ACC_W   = (ACC_A > ACC_B) ? ACC_A : ACC_B;
    localparam int RND_W   = ACC_W - COEF_FRAC_BITS;

    localparam logic signed [STATE_WIDTH-1:0]  ST_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    localparam logic signed [STATE_WIDTH-1:0]  ST_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX  = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN  = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [ACC_W-1:0]        HALF   = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    coef_t                     coef_reg [NUM_COEFS];
    logic signed [STATE_WIDTH-1:0]  d1_reg, d2_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg, y_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic [STEP_W-1:0]              step_reg;
    logic                           busy_reg;
    logic                           clip_reg;
    logic                           out_valid_reg;
    logic [SAMPLE_WIDTH-1:0]        out_sample_reg;
    logic                           out_clip_reg;

    ucode_t                         ctrl;
    logic                           s_accept, cfg_write, out_free, advance, finish;
    logic signed [SAMPLE_WIDTH-1:0] mul_op;
    logic signed [PROD_W-1:0]       prod_next;
    logic signed [ACC_W-1:0]        base, sum;
    logic                           st_ovf;
    logic signed [STATE_WIDTH-1:0]  st_sat;
    logic signed [ACC_W-1:0]        rnd_full;
    logic signed [RND_W-1:0]        rnd;
    logic                           y_ovf;
    logic signed [SAMPLE_WIDTH-1:0] y_next;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign s_tready  = !busy_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    assign ctrl    = ucode_word(step_reg);
    // hold the final step while the output register is still occupied
    assign advance = busy_reg && !(ctrl.last && !out_free);
    assign finish  = advance && ctrl.last;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_sample_reg);
    assign m_tuser  = out_clip_reg;

    // multiplier
    always_comb begin
        mul_op    = (ctrl.mul_src == MUL_Y) ? y_reg : x_reg;
        prod_next = PROD_W'(coef_reg[ctrl.coef_sel]) * PROD_W'(mul_op);
    end

    // adder and state saturation
    always_comb begin
        case (ctrl.base_sel)
            BASE_ACC: base = acc_reg;
            BASE_D1:  base = ACC_W'(d1_reg);
            BASE_D2:  base = ACC_W'(d2_reg);
            default:  base = '0;
        endcase
        sum    = ctrl.sub ? (base - ACC_W'(prod_reg)) : (base + ACC_W'(prod_reg));
        st_ovf = (sum[ACC_W-1:STATE_WIDTH-1] != '0) && (sum[ACC_W-1:STATE_WIDTH-1] != '1);
        st_sat = st_ovf ? (sum[ACC_W-1] ? ST_MIN : ST_MAX) : sum[STATE_WIDTH-1:0];
    end

    // round half up, then saturate to the sample range
    always_comb begin
        rnd_full = acc_reg + HALF;
        rnd      = rnd_full[ACC_W-1:COEF_FRAC_BITS];
        y_ovf    = (rnd[RND_W-1:SAMPLE_WIDTH-1] != '0) && (rnd[RND_W-1:SAMPLE_WIDTH-1] != '1);
        y_next   = y_ovf ? (rnd[RND_W-1] ? Y_MIN : Y_MAX) : rnd[SAMPLE_WIDTH-1:0];
    end

    // sequencer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (s_accept) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (finish) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (advance) begin
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    // coefficients and state words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[COEF_B0] <= COEF_WIDTH'(COEF_B0_RESET);
            coef_reg[COEF_B1] <= '0;
            coef_reg[COEF_B2] <= '0;
            coef_reg[COEF_A1] <= '0;
            coef_reg[COEF_A2] <= '0;
            d1_reg            <= '0;
            d2_reg            <= '0;
        end else if (cfg_write) begin
            if (cfg_index < CFG_INDEX_W'(NUM_COEFS)) begin
                coef_reg[cfg_index] <= cfg_data;
                d1_reg              <= '0;
                d2_reg              <= '0;
            end
        end else if (advance) begin
            if (ctrl.d1_en) d1_reg <= st_sat;
            if (ctrl.d2_en) d2_reg <= st_sat;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            x_reg <= s_tdata[SAMPLE_WIDTH-1:0];
        end
        if (advance) begin
            if (ctrl.mul_en) prod_reg <= prod_next;
            if (ctrl.acc_en) acc_reg  <= sum;
            if (ctrl.y_en)   y_reg    <= y_next;
        end
    end

    // clip flag gathers over one word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_reg <= 1'b0;
        end else if (s_accept) begin
            clip_reg <= 1'b0;
        end else if (advance) begin
            clip_reg <= clip_reg | (ctrl.y_en & y_ovf) | ((ctrl.d1_en | ctrl.d2_en) & st_ovf);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            out_sample_reg <= y_reg;
            out_clip_reg   <= clip_reg | (ctrl.d2_en & st_ovf);
        end
    end

endmodule
`default_nettype wire

// File: src/bqd_checker.sv
// Port-level checker for the biquad section and its bind to the top level.
`default_nettype none
module bqd_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_tvalid,
    input wire logic                               s_tready,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  m_tdata,
    input wire logic                               m_tuser
);

    // result channel is empty after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    // a stalled result keeps its word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result word changed or dropped");

    // a taken word closes the input
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after a word was taken");

    // a new result appears only at the end of a busy interval
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result word appeared without a word in work");

endmodule

bind biquad_iir_filter bqd_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_bqd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
